// File: rtl/scancode_to_ascii_translator_macros.svh
// Assertion macros shared by the RTL. Every macro samples on clk and is
// disabled while rst is high.
`ifndef SCANCODE_TO_ASCII_TRANSLATOR_MACROS_SVH
`define SCANCODE_TO_ASCII_TRANSLATOR_MACROS_SVH

// The consequent must hold in the cycle after the antecedent.
`define SCTA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("scta: next-cycle check failed");

// The consequent must hold in the same cycle as the antecedent.
`define SCTA_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scta: same-cycle check failed");

`endif

// File: rtl/scta_pkg.sv
`default_nettype none

package scta_pkg;

  // Set-1 make codes
  localparam logic [7:0] SC_CTRL     = 8'h1D;
  localparam logic [7:0] SC_ALT      = 8'h38;
  localparam logic [7:0] SC_LSHIFT   = 8'h2A;
  localparam logic [7:0] SC_RSHIFT   = 8'h36;
  localparam logic [7:0] SC_CAPS     = 8'h3A;
  localparam logic [7:0] SC_NUM      = 8'h45;
  localparam logic [7:0] SC_ENTER    = 8'h1C;
  localparam logic [7:0] SC_SPACE    = 8'h39;
  localparam logic [7:0] SC_BKSP     = 8'h0E;
  localparam logic [7:0] SC_EXTRA    = 8'h56;
  localparam logic [7:0] SC_KP_STAR  = 8'h37;
  localparam logic [7:0] SC_KP_PLUS  = 8'h4E;
  localparam logic [7:0] SC_KP_MINUS = 8'h4A;
  localparam logic [7:0] SC_KP_DOT   = 8'h53;
  localparam logic [7:0] SC_KP_0     = 8'h52;
  localparam logic [7:0] SC_KP_1     = 8'h4F;
  localparam logic [7:0] SC_KP_2     = 8'h50;
  localparam logic [7:0] SC_KP_3     = 8'h51;
  localparam logic [7:0] SC_KP_4     = 8'h4B;
  localparam logic [7:0] SC_KP_5     = 8'h4C;
  localparam logic [7:0] SC_KP_6     = 8'h4D;
  localparam logic [7:0] SC_KP_7     = 8'h47;
  localparam logic [7:0] SC_KP_8     = 8'h48;
  localparam logic [7:0] SC_KP_9     = 8'h49;

  localparam logic [7:0] BREAK_BIT   = 8'h80;

  // Break codes of the keys that carry state
  localparam logic [7:0] BK_CTRL   = SC_CTRL   | BREAK_BIT;
  localparam logic [7:0] BK_ALT    = SC_ALT    | BREAK_BIT;
  localparam logic [7:0] BK_LSHIFT = SC_LSHIFT | BREAK_BIT;
  localparam logic [7:0] BK_RSHIFT = SC_RSHIFT | BREAK_BIT;
  localparam logic [7:0] BK_CAPS   = SC_CAPS   | BREAK_BIT;
  localparam logic [7:0] BK_NUM    = SC_NUM    | BREAK_BIT;

  localparam int unsigned ASCII_W = 7;
  localparam logic [ASCII_W-1:0] CH_NONE = 7'h00;

  typedef struct packed {
    logic shift;
    logic ctrl;
    logic alt;
    logic caps;
    logic caps_pressed;
    logic num;
    logic num_pressed;
  } flags_t;

  typedef struct packed {
    logic               hit;
    logic               letter;
    logic [ASCII_W-1:0] plain;
    logic [ASCII_W-1:0] shifted;
  } key_entry_t;

  // 47-key main table: plain and shifted characters, letters marked.
  function automatic key_entry_t key_lookup(input logic [7:0] code);
    key_entry_t e;
    e = '{hit: 1'b1, letter: 1'b0, plain: CH_NONE, shifted: CH_NONE};
    unique case (code)
      8'h27: begin e.plain = 7'h3b; e.shifted = 7'h3a; end
      8'h0c: begin e.plain = 7'h2d; e.shifted = 7'h5f; end
      8'h0d: begin e.plain = 7'h3d; e.shifted = 7'h2b; end
      8'h1a: begin e.plain = 7'h5b; e.shifted = 7'h7b; end
      8'h1b: begin e.plain = 7'h5d; e.shifted = 7'h7d; end
      8'h28: begin e.plain = 7'h27; e.shifted = 7'h22; end
      8'h29: begin e.plain = 7'h60; e.shifted = 7'h7e; end
      8'h2b: begin e.plain = 7'h5c; e.shifted = 7'h7c; end
      8'h33: begin e.plain = 7'h2c; e.shifted = 7'h3c; end
      8'h34: begin e.plain = 7'h2e; e.shifted = 7'h3e; end
      8'h35: begin e.plain = 7'h2f; e.shifted = 7'h3f; end
      8'h0b: begin e.plain = 7'h30; e.shifted = 7'h29; end
      8'h02: begin e.plain = 7'h31; e.shifted = 7'h21; end
      8'h03: begin e.plain = 7'h32; e.shifted = 7'h40; end
      8'h04: begin e.plain = 7'h33; e.shifted = 7'h23; end
      8'h05: begin e.plain = 7'h34; e.shifted = 7'h24; end
      8'h06: begin e.plain = 7'h35; e.shifted = 7'h25; end
      8'h07: begin e.plain = 7'h36; e.shifted = 7'h5e; end
      8'h08: begin e.plain = 7'h37; e.shifted = 7'h26; end
      8'h09: begin e.plain = 7'h38; e.shifted = 7'h2a; end
      8'h0a: begin e.plain = 7'h39; e.shifted = 7'h28; end
      8'h1e: begin e.letter = 1'b1; e.plain = 7'h61; e.shifted = 7'h41; end
      8'h30: begin e.letter = 1'b1; e.plain = 7'h62; e.shifted = 7'h42; end
      8'h2e: begin e.letter = 1'b1; e.plain = 7'h63; e.shifted = 7'h43; end
      8'h20: begin e.letter = 1'b1; e.plain = 7'h64; e.shifted = 7'h44; end
      8'h12: begin e.letter = 1'b1; e.plain = 7'h65; e.shifted = 7'h45; end
      8'h21: begin e.letter = 1'b1; e.plain = 7'h66; e.shifted = 7'h46; end
      8'h22: begin e.letter = 1'b1; e.plain = 7'h67; e.shifted = 7'h47; end
      8'h23: begin e.letter = 1'b1; e.plain = 7'h68; e.shifted = 7'h48; end
      8'h17: begin e.letter = 1'b1; e.plain = 7'h69; e.shifted = 7'h49; end
      8'h24: begin e.letter = 1'b1; e.plain = 7'h6a; e.shifted = 7'h4a; end
      8'h25: begin e.letter = 1'b1; e.plain = 7'h6b; e.shifted = 7'h4b; end
      8'h26: begin e.letter = 1'b1; e.plain = 7'h6c; e.shifted = 7'h4c; end
      8'h32: begin e.letter = 1'b1; e.plain = 7'h6d; e.shifted = 7'h4d; end
      8'h31: begin e.letter = 1'b1; e.plain = 7'h6e; e.shifted = 7'h4e; end
      8'h18: begin e.letter = 1'b1; e.plain = 7'h6f; e.shifted = 7'h4f; end
      8'h19: begin e.letter = 1'b1; e.plain = 7'h70; e.shifted = 7'h50; end
      8'h10: begin e.letter = 1'b1; e.plain = 7'h71; e.shifted = 7'h51; end
      8'h13: begin e.letter = 1'b1; e.plain = 7'h72; e.shifted = 7'h52; end
      8'h1f: begin e.letter = 1'b1; e.plain = 7'h73; e.shifted = 7'h53; end
      8'h14: begin e.letter = 1'b1; e.plain = 7'h74; e.shifted = 7'h54; end
      8'h16: begin e.letter = 1'b1; e.plain = 7'h75; e.shifted = 7'h55; end
      8'h2f: begin e.letter = 1'b1; e.plain = 7'h76; e.shifted = 7'h56; end
      8'h11: begin e.letter = 1'b1; e.plain = 7'h77; e.shifted = 7'h57; end
      8'h2d: begin e.letter = 1'b1; e.plain = 7'h78; e.shifted = 7'h58; end
      8'h15: begin e.letter = 1'b1; e.plain = 7'h79; e.shifted = 7'h59; end
      8'h2c: begin e.letter = 1'b1; e.plain = 7'h7a; e.shifted = 7'h5a; end
      default: e.hit = 1'b0;
    endcase
    return e;
  endfunction

endpackage

`default_nettype wire

// File: rtl/scta_flags.sv
`default_nettype none

// Modifier and lock state. flags_next is the state after scan_byte and is
// committed when en is high.
module scta_flags (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            en,
  input  wire logic [7:0]      scan_byte,
  output scta_pkg::flags_t     flags_next,
  output scta_pkg::flags_t     flags
);
  import scta_pkg::*;

  always_comb begin
    flags_next = flags;
    unique case (scan_byte)
      SC_CTRL:   flags_next.ctrl  = 1'b1;
      BK_CTRL:   flags_next.ctrl  = 1'b0;
      SC_ALT:    flags_next.alt   = 1'b1;
      BK_ALT:    flags_next.alt   = 1'b0;
      SC_LSHIFT,
      SC_RSHIFT: flags_next.shift = 1'b1;
      BK_LSHIFT,
      BK_RSHIFT: flags_next.shift = 1'b0;
      SC_CAPS:   flags_next.caps_pressed = 1'b1;
      BK_CAPS: begin
        // toggle only on a release that follows a press
        flags_next.caps         = flags.caps ^ flags.caps_pressed;
        flags_next.caps_pressed = 1'b0;
      end
      SC_NUM:    flags_next.num_pressed = 1'b1;
      BK_NUM: begin
        flags_next.num         = flags.num ^ flags.num_pressed;
        flags_next.num_pressed = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flags <= '{shift: 1'b0, ctrl: 1'b0, alt: 1'b0, caps: 1'b0,
                 caps_pressed: 1'b0, num: 1'b1, num_pressed: 1'b0};
    end else if (en) begin
      flags <= flags_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/scta_xlate.sv
`default_nettype none

// Character lookup against the already updated flags.
module scta_xlate (
  input  wire logic                          [7:0] scan_byte,
  input  wire scta_pkg::flags_t                    flags,
  output logic [scta_pkg::ASCII_W-1:0]             ascii_char
);
  import scta_pkg::*;

  key_entry_t key;
  logic       upper;

  always_comb begin
    key   = key_lookup(scan_byte);
    // caps lock only flips letters
    upper = flags.shift ^ (flags.caps & key.letter);
  end

  always_comb begin
    unique case (scan_byte)
      SC_ENTER:    ascii_char = 7'h0a;
      SC_SPACE:    ascii_char = 7'h20;
      SC_BKSP:     ascii_char = 7'h08;
      SC_KP_0:     ascii_char = flags.num ? 7'h30 : CH_NONE;
      SC_KP_1:     ascii_char = flags.num ? 7'h31 : CH_NONE;
      SC_KP_2:     ascii_char = flags.num ? 7'h32 : CH_NONE;
      SC_KP_3:     ascii_char = flags.num ? 7'h33 : CH_NONE;
      SC_KP_4:     ascii_char = flags.num ? 7'h34 : CH_NONE;
      SC_KP_5:     ascii_char = flags.num ? 7'h35 : CH_NONE;
      SC_KP_6:     ascii_char = flags.num ? 7'h36 : CH_NONE;
      SC_KP_7:     ascii_char = flags.num ? 7'h37 : CH_NONE;
      SC_KP_8:     ascii_char = flags.num ? 7'h38 : CH_NONE;
      SC_KP_9:     ascii_char = flags.num ? 7'h39 : CH_NONE;
      SC_EXTRA:    ascii_char = flags.shift ? 7'h7c : 7'h5c;
      SC_KP_STAR:  ascii_char = 7'h2a;
      SC_KP_PLUS:  ascii_char = 7'h2b;
      SC_KP_MINUS: ascii_char = 7'h2d;
      SC_KP_DOT:   ascii_char = 7'h2e;
      default: begin
        if (key.hit) begin
          ascii_char = upper ? key.shifted : key.plain;
        end else begin
          ascii_char = CH_NONE;
        end
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/scancode_to_ascii_translator.sv
`default_nettype none

// Set-1 scan code to ASCII translator. Each s_tdata transfer is one scan
// code byte (bit 7 set = key release); each m_tdata transfer is the
// character it produces (0 if none) plus the shift, ctrl, alt, caps lock and
// num lock state after that byte. Exactly one result per byte, in order.
// Throughput is one byte per clock while m_tready keeps the output free: the
// byte lands in an input register, the flag update and the table lookup sit
// in one short combinational pass, and the result lands in an output register,
// which raises m_tvalid. After reset num lock is on, everything else off.
module scancode_to_ascii_translator (
  input  wire logic        clk,
  input  wire logic        rst,
  // input byte stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] scan_byte
  // result stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata    // [6:0] ascii_char, [7] shift_held,
                                      // [8] ctrl_held, [9] alt_held,
                                      // [10] caps_on, [11] num_on, [15:12] 0
);
  import scta_pkg::*;

  `include "scancode_to_ascii_translator_macros.svh"

  // input register
  logic        in_valid;
  logic [7:0]  in_byte;

  // output register payload
  logic [ASCII_W-1:0] res_ascii;
  flags_t             res_flags;

  flags_t             flags_next;
  flags_t             flags;
  logic [ASCII_W-1:0] ascii_next;

  logic out_free;
  logic advance;

  // Output slot is free when empty or being drained this cycle.
  assign out_free = !m_tvalid || m_tready;
  assign advance  = in_valid && out_free;
  assign s_tready = !in_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
    end
  end

  // flag state commits only as the byte moves to the output register
  scta_flags u_flags (
    .clk        (clk),
    .rst        (rst),
    .en         (advance),
    .scan_byte  (in_byte),
    .flags_next (flags_next),
    .flags      (flags)
  );

  scta_xlate u_xlate (
    .scan_byte  (in_byte),
    .flags      (flags_next),
    .ascii_char (ascii_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_ascii <= ascii_next;
      res_flags <= flags_next;
    end
  end

  assign m_tdata = {4'b0000, res_flags.num, res_flags.caps, res_flags.alt,
                    res_flags.ctrl, res_flags.shift, res_ascii};

  // A waiting byte with a free output slot always yields a result next cycle.
  `SCTA_ASSERT_NEXT(a_advance_fills, in_valid && out_free, m_tvalid)
  // Release codes never produce a character.
  `SCTA_ASSERT_NEXT(a_break_no_char, advance && in_byte[7], res_ascii == CH_NONE)
  // Lock state moves only with a byte.
  `SCTA_ASSERT_NEXT(a_lock_stable, !advance, $stable(flags.caps) && $stable(flags.num))
  // Reported state matches the live state when nothing is in flight.
  `SCTA_ASSERT_SAME(a_state_match, m_tvalid && !in_valid, res_flags == flags)

endmodule

`default_nettype wire
